/* hdl/tvq_pkg.sv */
`default_nettype none

package tvq_pkg;

	localparam int EDGE_LOG2        = 8;
	localparam int EDGE_MAX         = 1 << EDGE_LOG2;
	localparam int TEX_AW           = 2 * EDGE_LOG2;
	localparam int TEX_WORDS        = 1 << TEX_AW;
	localparam int CB_ENTRIES       = 256;
	localparam int CB_WORDS         = CB_ENTRIES * 4;
	localparam int CB_AW            = $clog2(CB_WORDS);

	localparam int COORD_W    = 8;
	localparam int DIM_W      = 9;
	localparam int SH_W       = $clog2(DIM_W);
	localparam int MORTON_W   = 2 * COORD_W;
	localparam int WORD_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [1:0] {
		REQ_TEXEL_WR    = 2'd0,
		REQ_CODEBOOK_WR = 2'd1,
		REQ_SAMPLE      = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		FMT_ARGB1555 = 2'd0,
		FMT_RGB565   = 2'd1,
		FMT_ARGB4444 = 2'd2
	} texel_fmt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH   = 3'd0,
		CFG_IMAGE_HEIGHT  = 3'd1,
		CFG_TEXEL_FORMAT  = 3'd2,
		CFG_MORTON_ORDER  = 3'd3,
		CFG_VQ_MODE       = 3'd4,
		CFG_CODEBOOK_SIZE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [15:0]        word_address;
		logic [15:0]        word_value;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
	} req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       coord_error;
	} rsp_t;

	// Outcome of the address stage for one sample.
	typedef struct packed {
		logic              coord_error;
		logic [TEX_AW-1:0] tex_addr;
		logic              byte_hi;
		logic [1:0]        sub;
	} addr_info_t;

endpackage

`default_nettype wire

/* hdl/twiddled_vq_texel_decode_unit.sv */
// Texel sampler for twiddled and VQ-compressed 16-bit textures.
// Request channel (req_valid/req_stall/req): a transfer carries either a word
// write into the texel store or the codebook store, or a sample at (x,y).
// Writes take effect at the transfer and produce no response; with no sample in
// flight the block can take a write every cycle. A sample produces one response
// on rsp_valid/rsp_stall/rsp with RGBA8888 color and a coordinate error flag.
// In VQ mode the codebook read follows the index read unless the index is past
// the codebook size; a coordinate outside the image skips the reads. One
// sample is in flight at a time, and no new request is taken until it is done:
// the texel memory read, the dependent codebook read and the output load run
// as steps of one sequencer. While the response register holds an untaken
// result, the next sample is still accepted; it waits in its last step until
// rsp_stall drops. Configuration writes go through cfg_valid/cfg_ready/
// cfg_index/cfg_data; the user must issue them only while no sample is
// outstanding, which the block itself does not enforce.
// Reset clears the sequencer and the response valid and loads the default
// configuration (256x256, ARGB1555, Morton order, VQ off, 256 codebook
// entries). Store contents are undefined until written.
`default_nettype none

module twiddled_vq_texel_decode_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  tvq_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output tvq_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tvq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tvq_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_TEX, S_CB, S_OUT} state_t;

	state_t            state_q;
	logic [DIM_W-1:0]  width_q, height_q, cb_size_q, cb_lim;
	logic [1:0]        format_q;
	logic              morton_q, vq_q;

	addr_info_t        info, info_q;
	logic              fire, sample_ok;
	logic              tex_we, tex_re, cb_we, cb_re;
	logic [31:0]       wa_wide;
	logic [WORD_W-1:0] tex_rd_q, cb_rd_q, texel_q;
	logic              err_q;
	logic [7:0]        entry;
	logic [9:0]        cb_index;
	logic [CB_AW-1:0]  cb_ra;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [WORD_W-1:0] texel_mem [TEX_WORDS];
	logic [WORD_W-1:0] cb_mem    [CB_WORDS];

	function automatic rsp_t unpack(input logic [WORD_W-1:0] t, input logic [1:0] fmt);
		rsp_t o;
		o.coord_error = 1'b0;
		case (fmt)
			FMT_RGB565: begin
				o.red   = {t[15:11], t[15:13]};
				o.green = {t[10:5], t[10:9]};
				o.blue  = {t[4:0], t[4:2]};
				o.alpha = 8'hff;
			end
			FMT_ARGB1555: begin
				o.red   = {t[14:10], t[14:12]};
				o.green = {t[9:5], t[9:7]};
				o.blue  = {t[4:0], t[4:2]};
				o.alpha = {8{t[15]}};
			end
			default: begin
				o.red   = {t[11:8], t[11:8]};
				o.green = {t[7:4], t[7:4]};
				o.blue  = {t[3:0], t[3:0]};
				o.alpha = {t[15:12], t[15:12]};
			end
		endcase
		return o;
	endfunction

	tvq_addr u_addr (
		.image_width  (width_q),
		.image_height (height_q),
		.morton_order (morton_q),
		.vq_mode      (vq_q),
		.coord_x      (req.coord_x),
		.coord_y      (req.coord_y),
		.info         (info)
	);

	assign req_stall = (state_q != S_IDLE);
	assign fire      = req_valid && !req_stall;
	assign wa_wide   = 32'(req.word_address);
	assign cfg_ready = 1'b1;

	assign tex_we    = fire && (req.req_type == REQ_TEXEL_WR) && (wa_wide < TEX_WORDS);
	assign cb_we     = fire && (req.req_type == REQ_CODEBOOK_WR) && (wa_wide < CB_WORDS);
	assign sample_ok = fire && (req.req_type == REQ_SAMPLE);
	assign tex_re    = sample_ok && !info.coord_error;

	// Codebook lookup from the index byte fetched in the previous step.
	assign cb_lim   = (32'(cb_size_q) > CB_ENTRIES) ? DIM_W'(CB_ENTRIES) : cb_size_q;
	assign entry    = info_q.byte_hi ? tex_rd_q[15:8] : tex_rd_q[7:0];
	assign cb_index = {entry, info_q.sub};
	assign cb_ra    = cb_index[CB_AW-1:0];
	assign cb_re    = (state_q == S_TEX) && vq_q && (DIM_W'(entry) < cb_lim);

	always_ff @(posedge clk) begin
		if (tex_we) begin
			texel_mem[wa_wide[TEX_AW-1:0]] <= req.word_value;
		end
		if (tex_re) begin
			tex_rd_q <= texel_mem[info.tex_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cb_we) begin
			cb_mem[wa_wide[CB_AW-1:0]] <= req.word_value;
		end
		if (cb_re) begin
			cb_rd_q <= cb_mem[cb_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DIM_W'(256);
			height_q  <= DIM_W'(256);
			format_q  <= FMT_ARGB1555;
			morton_q  <= 1'b1;
			vq_q      <= 1'b0;
			cb_size_q <= DIM_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:   width_q   <= cfg_data;
				CFG_IMAGE_HEIGHT:  height_q  <= cfg_data;
				CFG_TEXEL_FORMAT:  format_q  <= cfg_data[1:0];
				CFG_MORTON_ORDER:  morton_q  <= cfg_data[0];
				CFG_VQ_MODE:       vq_q      <= cfg_data[0];
				CFG_CODEBOOK_SIZE: cb_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// In the output step the response register is handled below.
			if (rsp_valid_q && !rsp_stall && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					info_q <= info;
					if (sample_ok) begin
						err_q   <= info.coord_error;
						texel_q <= '0;
						state_q <= info.coord_error ? S_OUT : S_TEX;
					end
				end
				S_TEX: begin
					if (!vq_q) begin
						texel_q <= tex_rd_q;
						state_q <= S_OUT;
					end else if (cb_re) begin
						state_q <= S_CB;
					end else begin
						// Index past the codebook size decodes as texel zero.
						texel_q <= '0;
						state_q <= S_OUT;
					end
				end
				S_CB: begin
					texel_q <= cb_rd_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						if (err_q) begin
							rsp_q <= '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0,
								coord_error: 1'b1};
						end else begin
							rsp_q <= unpack(texel_q, format_q);
						end
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* hdl/tvq_addr.sv */
`default_nettype none

module tvq_addr (
	input  logic [tvq_pkg::DIM_W-1:0]   image_width,
	input  logic [tvq_pkg::DIM_W-1:0]   image_height,
	input  logic                        morton_order,
	input  logic                        vq_mode,
	input  logic [tvq_pkg::COORD_W-1:0] coord_x,
	input  logic [tvq_pkg::COORD_W-1:0] coord_y,
	output tvq_pkg::addr_info_t         info
);
	import tvq_pkg::*;

	logic [DIM_W-1:0]    w, h, dmin;
	logic [SH_W-1:0]     sh;
	logic [MORTON_W-1:0] morton, hi_part;
	logic [COORD_W-1:0]  hi_bits;
	logic [DIM_W+COORD_W:0] stride;
	logic [31:0]         morton_wide, vq_wide, stride_wide;

	function automatic logic [DIM_W-1:0] clamp_edge(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > EDGE_MAX) begin
			r = DIM_W'(EDGE_MAX);
		end
		return r;
	endfunction

	assign w    = clamp_edge(image_width);
	assign h    = clamp_edge(image_height);
	assign dmin = (w < h) ? w : h;

	// Floor of log2 of the smaller edge: position of the highest set bit.
	always_comb begin
		sh = '0;
		for (int i = 0; i < DIM_W; i++) begin
			if (dmin[i]) begin
				sh = SH_W'(i);
			end
		end
	end

	// Low sh bits of y go to even address bits, those of x to odd bits.
	always_comb begin
		morton = '0;
		for (int i = 0; i < COORD_W; i++) begin
			if (SH_W'(i) < sh) begin
				morton[2*i]   = coord_y[i];
				morton[2*i+1] = coord_x[i];
			end
		end
		hi_bits = (coord_x | coord_y) >> sh;
		hi_part = MORTON_W'(hi_bits) << {sh, 1'b0};
		morton  = morton | hi_part;
	end

	assign stride      = (DIM_W+COORD_W+1)'(coord_y) * (DIM_W+COORD_W+1)'(w)
		+ (DIM_W+COORD_W+1)'(coord_x);
	assign morton_wide = 32'(morton);
	assign vq_wide     = 32'(morton >> 3);
	assign stride_wide = 32'(stride);

	always_comb begin
		info.coord_error = (DIM_W'(coord_x) >= w) || (DIM_W'(coord_y) >= h);
		info.byte_hi     = morton[2];
		info.sub         = morton[1:0];
		if (vq_mode) begin
			info.tex_addr = vq_wide[TEX_AW-1:0];
		end else if (morton_order) begin
			info.tex_addr = morton_wide[TEX_AW-1:0];
		end else begin
			info.tex_addr = stride_wide[TEX_AW-1:0];
		end
	end

endmodule

`default_nettype wire

/* hdl/tvq_checker.sv */
`default_nettype none

module tvq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input tvq_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input tvq_pkg::rsp_t rsp
);
	import tvq_pkg::*;

	// A response held back by the receiver keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// An out-of-range sample carries no color.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.coord_error |->
			rsp.red == 8'd0 && rsp.green == 8'd0 && rsp.blue == 8'd0 && rsp.alpha == 8'd0)
		else $error("coordinate error with nonzero color");

	// A sample transfer occupies the sequencer in the following cycle.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.req_type == REQ_SAMPLE |=> req_stall)
		else $error("sample transfer did not occupy the block");

	// A new response only appears at the end of a sample in flight.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without a sample in flight");

endmodule

bind twiddled_vq_texel_decode_unit tvq_checker u_tvq_checker (.*);

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
	import tvq_pkg::*;

	// Codes that the package leaves without a name.
	localparam logic [1:0]           REQ_UNUSED = 2'd3;
	localparam logic [1:0]           FMT_SPARE  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
	localparam int                   PHASES     = 12;
	localparam int                   PHASE_ITEMS = 135;

	class pixel_scoreboard;
		logic [15:0] texel_mem [TEX_WORDS];
		bit          texel_known [TEX_WORDS];
		logic [15:0] codebook_mem [CB_WORDS];
		bit          codebook_known [CB_WORDS];
		logic [8:0]  width_reg;
		logic [8:0]  height_reg;
		logic [8:0]  cb_size_reg;
		logic [1:0]  format_reg;
		logic        morton_reg;
		logic        vq_reg;
		rsp_t        expected_pixels [$];
		int          errors;

		function new();
			width_reg   = 9'd256;
			height_reg  = 9'd256;
			cb_size_reg = 9'd256;
			format_reg  = FMT_ARGB1555;
			morton_reg  = 1'b1;
			vq_reg      = 1'b0;
			errors      = 0;
		endfunction

		function int unsigned edge_len(logic [8:0] v);
			if (v == 0)
				return 1;
			return (v > EDGE_MAX) ? EDGE_MAX : v;
		endfunction

		function int unsigned entry_limit();
			return (cb_size_reg > CB_ENTRIES) ? CB_ENTRIES : cb_size_reg;
		endfunction

		function bit in_image(int unsigned x, int unsigned y);
			return x < edge_len(width_reg) && y < edge_len(height_reg);
		endfunction

		// Linear texel position. Morton order puts y in the even bits over the
		// shared square part; whatever is left of x|y goes above it.
		function int unsigned texel_pos(int unsigned x, int unsigned y);
			int unsigned w, h, sh, m, lo, i;
			w = edge_len(width_reg);
			h = edge_len(height_reg);
			if (!vq_reg && !morton_reg)
				return y * w + x;
			sh = 0;
			m = (w < h) ? w : h;
			while (m > 1) begin
				m = m >> 1;
				sh++;
			end
			m = (1 << sh) - 1;
			lo = 0;
			for (i = 0; i < 8; i++)
				lo |= ((((y & m) >> i) & 1) << (2 * i)) |
				      ((((x & m) >> i) & 1) << (2 * i + 1));
			return lo | (((x | y) >> sh) << (2 * sh));
		endfunction

		function int unsigned plain_addr(int unsigned x, int unsigned y);
			return texel_pos(x, y) & (TEX_WORDS - 1);
		endfunction

		function int unsigned index_addr(int unsigned x, int unsigned y);
			return (texel_pos(x, y) >> 3) & (TEX_WORDS - 1);
		endfunction

		// Codebook word for a VQ texel, or -1 when the index is past the codebook.
		function int codebook_addr(int unsigned x, int unsigned y);
			int unsigned t, entry;
			logic [15:0] word;
			t = texel_pos(x, y);
			word = texel_mem[index_addr(x, y)];
			entry = ((t >> 2) & 1) ? word[15:8] : word[7:0];
			if (entry >= entry_limit())
				return -1;
			return (entry * 4 + (t & 3)) % CB_WORDS;
		endfunction

		function rsp_t predict_pixel(int unsigned x, int unsigned y);
			rsp_t p;
			logic [15:0] t;
			int c;
			p = '0;
			if (!in_image(x, y)) begin
				p.coord_error = 1'b1;
				return p;
			end
			if (vq_reg) begin
				c = codebook_addr(x, y);
				t = (c < 0) ? 16'h0000 : codebook_mem[c];
			end else begin
				t = texel_mem[plain_addr(x, y)];
			end
			case (format_reg)
				FMT_RGB565: begin
					p.red   = {t[15:11], t[15:13]};
					p.green = {t[10:5], t[10:9]};
					p.blue  = {t[4:0], t[4:2]};
					p.alpha = 8'hff;
				end
				FMT_ARGB1555: begin
					p.red   = {t[14:10], t[14:12]};
					p.green = {t[9:5], t[9:7]};
					p.blue  = {t[4:0], t[4:2]};
					p.alpha = {8{t[15]}};
				end
				default: begin
					p.red   = {2{t[11:8]}};
					p.green = {2{t[7:4]}};
					p.blue  = {2{t[3:0]}};
					p.alpha = {2{t[15:12]}};
				end
			endcase
			return p;
		endfunction

		function void note_request(req_t r);
			case (r.req_type)
				REQ_TEXEL_WR: begin
					texel_mem[r.word_address]   = r.word_value;
					texel_known[r.word_address] = 1'b1;
				end
				REQ_CODEBOOK_WR: begin
					if (r.word_address < CB_WORDS) begin
						codebook_mem[r.word_address]   = r.word_value;
						codebook_known[r.word_address] = 1'b1;
					end
				end
				REQ_SAMPLE: expected_pixels.push_back(predict_pixel(r.coord_x, r.coord_y));
				default: ;
			endcase
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_IMAGE_WIDTH:   width_reg   = d;
				CFG_IMAGE_HEIGHT:  height_reg  = d;
				CFG_TEXEL_FORMAT:  format_reg  = d[1:0];
				CFG_MORTON_ORDER:  morton_reg  = d[0];
				CFG_VQ_MODE:       vq_reg      = d[0];
				CFG_CODEBOOK_SIZE: cb_size_reg = d;
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_pixel(rsp_t got);
			rsp_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("pixel %h with none pending", got));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.red !== want.red)
				report($sformatf("red %h, want %h", got.red, want.red));
			if (got.green !== want.green)
				report($sformatf("green %h, want %h", got.green, want.green));
			if (got.blue !== want.blue)
				report($sformatf("blue %h, want %h", got.blue, want.blue));
			if (got.alpha !== want.alpha)
				report($sformatf("alpha %h, want %h", got.alpha, want.alpha));
			if (got.coord_error !== want.coord_error)
				report($sformatf("coord_error %b, want %b", got.coord_error,
					want.coord_error));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pixel_scoreboard sb;
	bit              calm = 1'b0;
	int              accepted_items = 0;

	twiddled_vq_texel_decode_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 32);
	end

	// Outputs are settled at the falling edge; a response seen here with stall
	// low completes its transfer at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_pixel(rsp);
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	function automatic req_t random_req(logic [1:0] kind);
		req_t r;
		r.req_type     = kind;
		r.word_address = 16'($urandom);
		r.word_value   = 16'($urandom);
		r.coord_x      = COORD_W'($urandom);
		r.coord_y      = COORD_W'($urandom);
		return r;
	endfunction

	// Index words mostly point inside the codebook so that decoding is exercised.
	function automatic logic [15:0] index_word();
		int unsigned lim;
		logic [15:0] w;
		lim = sb.entry_limit();
		w = 16'($urandom);
		if (lim > 0 && $urandom_range(3) != 0)
			w[7:0] = 8'($urandom_range(lim - 1));
		if (lim > 0 && $urandom_range(3) != 0)
			w[15:8] = 8'($urandom_range(lim - 1));
		return w;
	endfunction

	task automatic issue(req_t r);
		bit took;
		if (!calm && $urandom_range(99) < 32) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = !req_stall;
			@(posedge clk);
		end while (!took);
		sb.note_request(r);
		if (!(r.req_type == REQ_UNUSED ||
		      (r.req_type == REQ_CODEBOOK_WR && r.word_address >= CB_WORDS)))
			accepted_items++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_pixels.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		bit took;
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		sb.note_config(idx, d);
	endtask

	task automatic setup(logic [8:0] w, logic [8:0] h, logic [8:0] fmt, logic [8:0] mort,
			logic [8:0] vq, logic [8:0] cb);
		wait_drained();
		// Writes leave no response behind, so give the sequencer time to settle.
		repeat (8) @(posedge clk);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_TEXEL_FORMAT, fmt);
		write_reg(CFG_MORTON_ORDER, mort);
		write_reg(CFG_VQ_MODE, vq);
		write_reg(CFG_CODEBOOK_SIZE, cb);
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Fills in whatever the sample will read before issuing it, so that no
	// unwritten store word is ever fetched.
	task automatic sample_at(int unsigned x, int unsigned y);
		req_t r;
		int a;
		if (sb.in_image(x, y)) begin
			if (!sb.vq_reg) begin
				a = sb.plain_addr(x, y);
				if (!sb.texel_known[a]) begin
					r = random_req(REQ_TEXEL_WR);
					r.word_address = 16'(a);
					issue(r);
				end
			end else begin
				a = sb.index_addr(x, y);
				if (!sb.texel_known[a]) begin
					r = random_req(REQ_TEXEL_WR);
					r.word_address = 16'(a);
					r.word_value = index_word();
					issue(r);
				end
				a = sb.codebook_addr(x, y);
				if (a >= 0 && !sb.codebook_known[a]) begin
					r = random_req(REQ_CODEBOOK_WR);
					r.word_address = 16'(a);
					issue(r);
				end
			end
		end
		r = random_req(REQ_SAMPLE);
		r.coord_x = COORD_W'(x);
		r.coord_y = COORD_W'(y);
		issue(r);
	endtask

	function automatic logic [8:0] pick_edge();
		if ($urandom_range(3) == 0)
			return 9'($urandom_range(511));
		return 9'd1 << $urandom_range(8);
	endfunction

	initial begin
		req_t r;
		int unsigned w, h, x, y, roll, base;
		sb = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration: corner addresses of the
		// twiddled 256x256 store, ignored writes and the unused request type.
		r = random_req(REQ_TEXEL_WR);
		r.word_address = 16'h0000;
		r.word_value = 16'hffff;
		issue(r);
		r.word_address = 16'hffff;
		r.word_value = 16'h0000;
		issue(r);
		r.word_address = 16'h5555;
		r.word_value = 16'h8000;
		issue(r);
		r.word_address = 16'haaaa;
		r.word_value = 16'h7fff;
		issue(r);
		sample_at(0, 0);
		sample_at(255, 255);
		sample_at(0, 255);
		sample_at(255, 0);
		r = random_req(REQ_CODEBOOK_WR);
		r.word_address = 16'(CB_WORDS - 1);
		issue(r);
		r.word_address = 16'(CB_WORDS);
		issue(r);
		r.word_address = 16'hffff;
		issue(r);
		r.word_address = 16'h0000;
		issue(r);
		r = '1;
		r.req_type = REQ_UNUSED;
		issue(r);
		r = '0;
		r.req_type = REQ_UNUSED;
		issue(r);
		sample_at(128, 64);

		base = accepted_items;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:  setup(16, 8, FMT_RGB565, 1, 0, 256);
				1:  setup(0, 511, FMT_ARGB4444, 0, 0, 16);
				2:  setup(256, 256, FMT_SPARE, 0, 0, 0);
				3:  setup(12, 20, FMT_ARGB1555, 1, 0, 300);
				4:  setup(32, 64, FMT_ARGB1555, 0, 1, 16);
				5:  setup(256, 256, FMT_RGB565, 1, 1, 511);
				6:  setup(8, 8, FMT_ARGB4444, 1, 1, 0);
				7:  setup(1, 1, FMT_RGB565, 0, 0, 256);
				8:  setup(300, 2, FMT_ARGB1555, 1, 1, 255);
				default: setup(pick_edge(), pick_edge(),
					9'($urandom), 9'($urandom), 9'($urandom),
					9'($urandom_range(511)));
			endcase
			calm = (phase == 2 || phase == 5);
			w = sb.edge_len(sb.width_reg);
			h = sb.edge_len(sb.height_reg);
			sample_at(0, 0);
			sample_at(w - 1, h - 1);
			if (w < 256)
				sample_at(w, 0);
			if (h < 256)
				sample_at(0, h);
			while (accepted_items < base + (phase + 1) * PHASE_ITEMS) begin
				if ($urandom_range(149) == 0)
					wait_drained();
				roll = $urandom_range(99);
				if (roll < 6) begin
					issue(random_req(REQ_TEXEL_WR));
				end else if (roll < 10) begin
					r = random_req(REQ_CODEBOOK_WR);
					if ($urandom_range(3) != 0)
						r.word_address = 16'($urandom_range(CB_WORDS - 1));
					issue(r);
				end else if (roll < 13) begin
					issue(random_req(REQ_UNUSED));
				end else begin
					roll = $urandom_range(99);
					if (roll < 12 && (w < 256 || h < 256)) begin
						x = $urandom_range(255);
						y = $urandom_range(255);
						if (w < 256)
							x = $urandom_range(255, w);
						else
							y = $urandom_range(255, h);
					end else if (roll < 40) begin
						// Stay near the origin so stored words get read again.
						x = $urandom_range((w > 4) ? 3 : w - 1);
						y = $urandom_range((h > 4) ? 3 : h - 1);
					end else begin
						x = $urandom_range(w - 1);
						y = $urandom_range(h - 1);
					end
					sample_at(x, y);
				end
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
